// File: src/cpea_pkg.sv
package cpea_pkg;

    // Field widths of the stream items
    localparam int SLOT_W    = 6;
    localparam int UNITS_W   = 4;
    localparam int RES_W     = 10;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 3;
    localparam int PIN_W     = 8;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    // Defaults for the top-level parameters
    localparam int DEF_SLOTS     = 64;
    localparam int DEF_MAX_UNITS = 8;

    // Reset value of the budget register
    localparam logic [RES_W-1:0] BUDGET_RESET = 10'd512;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADMIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEAL   = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HIT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MISS   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VICTIM = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADMIT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd5;

    localparam logic [PIN_W-1:0] PIN_MAX = 8'd255;

endpackage

// File: src/clock_page_eviction_admission.sv
// CLOCK second-chance page admission over SLOTS slots. An item carries a command in s_tuser
// (admit, lookup, unpin, seal) and gives one or more result items ending with m_tlast. An admit
// that is not rejected up front runs one victim search for each victim it evicts, walking the
// hand and then testing and removing the victim, and finishes with a reject or with an insert
// into an empty ring or into a ring that already holds slots. A full victim search walks at
// most twice the ring length. The block takes no new item until the last result of the
// current one has been loaded into the output register.
module clock_page_eviction_admission #(
    parameter int SLOTS     = cpea_pkg::DEF_SLOTS,
    parameter int MAX_UNITS = cpea_pkg::DEF_MAX_UNITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cpea_pkg::RES_W-1:0]      cfg_wr_data,    // budget_units
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cpea_pkg::S_DATA_W-1:0]   s_tdata,    // page_slot, page_units, seal_flag
    input  logic [cpea_pkg::CMD_W-1:0]      s_tuser,    // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cpea_pkg::M_DATA_W-1:0]   m_tdata,    // slot_out, resident_out
    output logic [cpea_pkg::KIND_W-1:0]     m_tuser,    // kind
    output logic                            m_tlast     // last_flag
);
    import cpea_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LK_WB, S_UNPIN_WB, S_SEAL, S_ADM_CHECK, S_EV_TEST, S_SCAN_RD,
        S_SCAN_EV, S_EV_REM, S_ADM_FINAL, S_INS_RD, S_INS_WR1, S_INS_WR2, S_INS_EMPTY
    } state_t;

    state_t state_reg, state_next;

    // Per-slot flags with reset values
    logic [SLOTS-1:0] on_ring_reg, on_ring_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] sealed_reg, sealed_next;
    logic [SLOTS-1:0] pin_vld_reg, pin_vld_next;

    logic [IDX_W-1:0] hand_reg, hand_next;
    logic [CNT_W-1:0] ring_reg, ring_next;
    logic [RES_W-1:0] res_reg, res_next;
    logic [RES_W-1:0] budget_reg;

    // Item being worked on and search counters
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [UNITS_W-1:0] units_reg, units_next;
    logic               flag_reg, flag_next;
    logic [SLOT_W-1:0]  k_reg, k_next;
    logic [CNT_W:0]     tries_reg, tries_next;
    logic [CNT_W:0]     att_reg, att_next;
    logic [IDX_W-1:0]   c_reg, c_next;

    // Output register
    logic                mv_reg, mv_next;
    logic [KIND_W-1:0]   okind_reg, okind_next;
    logic [SLOT_W-1:0]   oslot_reg, oslot_next;
    logic [RES_W-1:0]    ores_reg, ores_next;
    logic                olast_reg, olast_next;

    // Link, size and pin memories
    logic [IDX_W-1:0]   next_mem [SLOTS];
    logic [IDX_W-1:0]   prev_mem [SLOTS];
    logic [UNITS_W-1:0] units_mem [SLOTS];
    logic [PIN_W-1:0]   pin_mem [SLOTS];

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   nxt_rd, prv_rd;
    logic [UNITS_W-1:0] unt_rd;
    logic [PIN_W-1:0]   pin_raw;
    logic               pin_vld_q;
    logic [PIN_W-1:0]   pin_rd;

    logic               nx_we, pv_we, un_we, pn_we;
    logic [IDX_W-1:0]   nx_wa, nx_wd, pv_wa, pv_wd, un_wa, pn_wa;
    logic [UNITS_W-1:0] un_wd;
    logic [PIN_W-1:0]   pn_wd;

    logic               out_free;
    logic [IDX_W-1:0]   s_idx;
    logic               slot_ok;
    logic [RES_W-1:0]   budget_eff;
    logic               fits;
    logic               size_ok;

    assign out_free   = !mv_reg || m_tready;
    assign s_idx      = slot_reg[IDX_W-1:0];
    assign slot_ok    = {1'b0, slot_reg} < (SLOT_W + 1)'(SLOTS);
    assign budget_eff = (budget_reg == '0) ? RES_W'(1) : budget_reg;
    assign fits       = ({1'b0, res_reg} + (RES_W + 1)'(units_reg)) <= {1'b0, budget_eff};
    assign size_ok    = (units_reg != '0) && ({1'b0, units_reg} <= (UNITS_W + 1)'(MAX_UNITS));
    assign pin_rd     = pin_vld_q ? pin_raw : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = {ores_reg, oslot_reg};
    assign m_tlast  = olast_reg;

    // Memories: one write and one registered read each cycle
    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we) begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (un_we) begin
            units_mem[un_wa] <= un_wd;
        end
        if (pn_we) begin
            pin_mem[pn_wa] <= pn_wd;
        end
        if (rd_en) begin
            nxt_rd    <= next_mem[rd_addr];
            prv_rd    <= prev_mem[rd_addr];
            unt_rd    <= units_mem[rd_addr];
            pin_raw   <= pin_mem[rd_addr];
            pin_vld_q <= pin_vld_reg[rd_addr];
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        on_ring_next = on_ring_reg;
        used_next    = used_reg;
        sealed_next  = sealed_reg;
        pin_vld_next = pin_vld_reg;
        hand_next    = hand_reg;
        ring_next    = ring_reg;
        res_next     = res_reg;
        slot_next    = slot_reg;
        units_next   = units_reg;
        flag_next    = flag_reg;
        k_next       = k_reg;
        tries_next   = tries_reg;
        att_next     = att_reg;
        c_next       = c_reg;
        mv_next      = mv_reg && !m_tready;
        okind_next   = okind_reg;
        oslot_next   = oslot_reg;
        ores_next    = ores_reg;
        olast_next   = olast_reg;
        rd_en        = 1'b0;
        rd_addr      = hand_reg;
        nx_we = 1'b0; nx_wa = s_idx; nx_wd = s_idx;
        pv_we = 1'b0; pv_wa = s_idx; pv_wd = s_idx;
        un_we = 1'b0; un_wa = s_idx; un_wd = units_reg;
        pn_we = 1'b0; pn_wa = s_idx; pn_wd = pin_rd;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    slot_next  = s_tdata[SLOT_W-1:0];
                    units_next = s_tdata[SLOT_W+UNITS_W-1:SLOT_W];
                    flag_next  = s_tdata[SLOT_W+UNITS_W];
                    rd_en      = 1'b1;
                    rd_addr    = s_tdata[IDX_W-1:0];
                    case (s_tuser)
                        CMD_ADMIT:  state_next = S_ADM_CHECK;
                        CMD_LOOKUP: state_next = S_LK_WB;
                        CMD_UNPIN:  state_next = S_UNPIN_WB;
                        default:    state_next = S_SEAL;
                    endcase
                end
            end
            S_LK_WB: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    oslot_next = slot_reg;
                    ores_next  = res_reg;
                    olast_next = 1'b1;
                    if (slot_ok && on_ring_reg[s_idx]) begin
                        pn_we               = 1'b1;
                        pn_wd               = (pin_rd == PIN_MAX) ? pin_rd : pin_rd + 1'b1;
                        pin_vld_next[s_idx] = 1'b1;
                        used_next[s_idx]    = 1'b1;
                        okind_next          = KIND_HIT;
                    end else begin
                        okind_next = KIND_MISS;
                    end
                    state_next = S_IDLE;
                end
            end
            S_UNPIN_WB: begin
                if (out_free) begin
                    if (slot_ok && pin_rd != '0) begin
                        pn_we               = 1'b1;
                        pn_wd               = pin_rd - 1'b1;
                        pin_vld_next[s_idx] = 1'b1;
                    end
                    mv_next    = 1'b1;
                    okind_next = KIND_DONE;
                    oslot_next = slot_reg;
                    ores_next  = res_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SEAL: begin
                if (out_free) begin
                    if (slot_ok) begin
                        sealed_next[s_idx] = flag_reg;
                    end
                    mv_next    = 1'b1;
                    okind_next = KIND_DONE;
                    oslot_next = slot_reg;
                    ores_next  = res_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ADM_CHECK: begin
                k_next = '0;
                if (!slot_ok || !size_ok || on_ring_reg[s_idx]) begin
                    if (out_free) begin
                        mv_next    = 1'b1;
                        okind_next = KIND_REJECT;
                        oslot_next = slot_reg;
                        ores_next  = res_reg;
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_EV_TEST;
                end
            end
            // Start one victim search when the page does not fit yet
            S_EV_TEST: begin
                if (!fits && k_reg != {SLOT_W{1'b1}}) begin
                    tries_next = {ring_reg, 1'b0};
                    att_next   = '0;
                    state_next = S_SCAN_RD;
                end else begin
                    state_next = S_ADM_FINAL;
                end
            end
            S_SCAN_RD: begin
                if (att_reg >= tries_reg) begin
                    state_next = S_ADM_FINAL;
                end else begin
                    c_next     = hand_reg;
                    rd_en      = 1'b1;
                    rd_addr    = hand_reg;
                    state_next = S_SCAN_EV;
                end
            end
            // Skip pinned and sealed slots, give used slots a second chance
            S_SCAN_EV: begin
                hand_next = nxt_rd;
                att_next  = att_reg + 1'b1;
                if (pin_rd != '0 || sealed_reg[c_reg]) begin
                    state_next = S_SCAN_RD;
                end else if (used_reg[c_reg]) begin
                    used_next[c_reg] = 1'b0;
                    state_next       = S_SCAN_RD;
                end else begin
                    state_next = S_EV_REM;
                end
            end
            // Unlink the victim and report it
            S_EV_REM: begin
                if (out_free) begin
                    if (nxt_rd != c_reg) begin
                        nx_we = 1'b1; nx_wa = prv_rd; nx_wd = nxt_rd;
                        pv_we = 1'b1; pv_wa = nxt_rd; pv_wd = prv_rd;
                    end
                    on_ring_next[c_reg] = 1'b0;
                    if (ring_reg != '0) begin
                        ring_next = ring_reg - 1'b1;
                    end
                    res_next   = (res_reg >= RES_W'(unt_rd)) ? res_reg - RES_W'(unt_rd) : '0;
                    mv_next    = 1'b1;
                    okind_next = KIND_VICTIM;
                    oslot_next = SLOT_W'(c_reg);
                    ores_next  = res_next;
                    olast_next = 1'b0;
                    k_next     = k_reg + 1'b1;
                    state_next = S_EV_TEST;
                end
            end
            S_ADM_FINAL: begin
                if (!fits) begin
                    if (out_free) begin
                        mv_next    = 1'b1;
                        okind_next = KIND_REJECT;
                        oslot_next = slot_reg;
                        ores_next  = res_reg;
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (ring_reg == '0) begin
                    state_next = S_INS_EMPTY;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: begin
                rd_en      = 1'b1;
                rd_addr    = hand_reg;
                state_next = S_INS_WR1;
            end
            // New slot sits between the tail and the hand
            S_INS_WR1: begin
                nx_we = 1'b1; nx_wa = s_idx; nx_wd = hand_reg;
                pv_we = 1'b1; pv_wa = s_idx; pv_wd = prv_rd;
                state_next = S_INS_WR2;
            end
            S_INS_WR2, S_INS_EMPTY: begin
                if (out_free) begin
                    if (state_reg == S_INS_WR2) begin
                        nx_we = 1'b1; nx_wa = prv_rd;   nx_wd = s_idx;
                        pv_we = 1'b1; pv_wa = hand_reg; pv_wd = s_idx;
                    end else begin
                        nx_we     = 1'b1;
                        pv_we     = 1'b1;
                        hand_next = s_idx;
                    end
                    un_we               = 1'b1;
                    used_next[s_idx]    = 1'b1;
                    on_ring_next[s_idx] = 1'b1;
                    ring_next           = ring_reg + 1'b1;
                    res_next            = res_reg + RES_W'(units_reg);
                    mv_next             = 1'b1;
                    okind_next          = KIND_ADMIT;
                    oslot_next          = slot_reg;
                    ores_next           = res_next;
                    olast_next          = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            on_ring_reg <= '0;
            used_reg    <= '0;
            sealed_reg  <= '0;
            pin_vld_reg <= '0;
            hand_reg    <= '0;
            ring_reg    <= '0;
            res_reg     <= '0;
            budget_reg  <= BUDGET_RESET;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            on_ring_reg <= on_ring_next;
            used_reg    <= used_next;
            sealed_reg  <= sealed_next;
            pin_vld_reg <= pin_vld_next;
            hand_reg    <= hand_next;
            ring_reg    <= ring_next;
            res_reg     <= res_next;
            mv_reg      <= mv_next;
            if (cfg_wr_en) begin
                budget_reg <= cfg_wr_data;
            end
        end
        slot_reg  <= slot_next;
        units_reg <= units_next;
        flag_reg  <= flag_next;
        k_reg     <= k_next;
        tries_reg <= tries_next;
        att_reg   <= att_next;
        c_reg     <= c_next;
        okind_reg <= okind_next;
        oslot_reg <= oslot_next;
        ores_reg  <= ores_next;
        olast_reg <= olast_next;
    end

    // The ring count always matches the number of slots on the ring.
    a_ring_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_reg == CNT_W'($countones(on_ring_reg)))
        else $error("ring count differs from ring membership");

    // A reported victim has left the ring.
    a_victim_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EV_REM && out_free) |=> !on_ring_reg[c_reg])
        else $error("victim still on ring");

endmodule
